// ===== hw/rtl/signed_int_to_decimal_ascii_top_defines.svh =====
// Assertion macros for the signed integer to decimal ASCII block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sitda_pkg.sv =====
// Shared constants for the signed integer to decimal ASCII block.
package sitda_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned DD_STEPS_DEF   = 4;

  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

endpackage

// ===== hw/rtl/sitda_dd_stage.sv =====
// One pipeline stage of the double-dabble binary to BCD converter.
module sitda_dd_stage #(
  parameter int unsigned NDIG  = 10,
  parameter int unsigned BIN_W = 32,
  parameter int unsigned STEPS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [BIN_W-1:0]  bin_i,
  input  logic [4*NDIG-1:0] bcd_i,
  input  logic              neg_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [BIN_W-1:0]  bin_o,
  output logic [4*NDIG-1:0] bcd_o,
  output logic              neg_o
);
  import sitda_pkg::*;

  logic              valid_q;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [4*NDIG-1:0] bcd_q, bcd_d;
  logic              neg_q;

  always_comb begin
    bin_d = bin_i;
    bcd_d = bcd_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int k = 0; k < NDIG; k++) begin
        if (bcd_d[4*k +: 4] >= BCD_ADJ_MIN) begin
          bcd_d[4*k +: 4] = bcd_d[4*k +: 4] + BCD_ADJ;
        end
      end
      bcd_d = {bcd_d[4*NDIG-2:0], bin_d[BIN_W-1]};
      bin_d = {bin_d[BIN_W-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      neg_q <= neg_i;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;
  assign neg_o   = neg_q;

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// Signed integer to decimal ASCII text converter, top level.
//
// Each accepted value comes out as its decimal text, one ASCII character per
// output request, most significant first, with a leading '-' for negative
// values and last_o on the final character; zero gives "0" and the most
// negative value converts exactly. The value passes an input register, then
// ceil(VALUE_BITS/DD_STEPS) double-dabble stages (8 at the defaults), then a
// character serializer. A new value can enter every cycle while the pipeline
// has room; sustained throughput is set by the serializer, which sends one
// character per cycle while out_ready_i is high; a value has 1 to 11
// characters at 32 bits, and the next value enters as the last one is taken.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF,
  parameter int unsigned DD_STEPS   = sitda_pkg::DD_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sitda_pkg::CHAR_W-1:0]  character_o,
  output logic                          last_o
);
  import sitda_pkg::*;
`include "signed_int_to_decimal_ascii_top_defines.svh"

  localparam int unsigned NDIG  = (VALUE_BITS * 301) / 1000 + 1;
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned NST   = (VALUE_BITS + DD_STEPS - 1) / DD_STEPS;
  localparam int unsigned BIN_W = NST * DD_STEPS;
  localparam int unsigned IDX_W = $clog2(NDIG);

  // Pipeline links: index 0 is the input register, NST the last dabble stage.
  logic [NST:0]     st_valid;
  logic [NST:0]     st_ready;
  logic [BIN_W-1:0] st_bin [NST+1];
  logic [BCD_W-1:0] st_bcd [NST+1];
  logic [NST:0]     st_neg;

  // Input register: sign and magnitude.
  logic                  in_valid_q;
  logic                  in_neg_q;
  logic [BIN_W-1:0]      in_bin_q;
  logic [VALUE_BITS-1:0] mag_d;

  assign mag_d      = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
  assign in_ready_o = !in_valid_q || st_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_neg_q <= value_i[VALUE_BITS-1];
      in_bin_q <= BIN_W'(mag_d);
    end
  end

  assign st_valid[0] = in_valid_q;
  assign st_bin[0]   = in_bin_q;
  assign st_bcd[0]   = '0;
  assign st_neg[0]   = in_neg_q;

  for (genvar s = 0; s < NST; s++) begin : g_dd
    sitda_dd_stage #(
      .NDIG (NDIG),
      .BIN_W(BIN_W),
      .STEPS(DD_STEPS)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_valid[s]),
      .ready_o(st_ready[s]),
      .bin_i  (st_bin[s]),
      .bcd_i  (st_bcd[s]),
      .neg_i  (st_neg[s]),
      .valid_o(st_valid[s+1]),
      .ready_i(st_ready[s+1]),
      .bin_o  (st_bin[s+1]),
      .bcd_o  (st_bcd[s+1]),
      .neg_o  (st_neg[s+1])
    );
  end

  // Character serializer.
  logic             ser_busy_q;
  logic             ser_minus_q;
  logic [IDX_W-1:0] ser_idx_q;
  logic [IDX_W-1:0] ser_idx_d;
  logic [BCD_W-1:0] ser_bcd_q;
  logic             ser_ready;
  logic [3:0]       ser_digit;

  always_comb begin
    ser_idx_d = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (st_bcd[NST][4*k +: 4] != 4'd0) begin
        ser_idx_d = IDX_W'(k);
      end
    end
  end

  assign ser_digit   = ser_bcd_q[4*ser_idx_q +: 4];
  assign out_valid_o = ser_busy_q;
  assign last_o      = !ser_minus_q && (ser_idx_q == '0);
  assign character_o = ser_minus_q ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(ser_digit));

  assign ser_ready       = !ser_busy_q || (out_ready_i && last_o);
  assign st_ready[NST]   = ser_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q  <= 1'b0;
      ser_minus_q <= 1'b0;
      ser_idx_q   <= '0;
    end else if (ser_ready) begin
      ser_busy_q <= st_valid[NST];
      if (st_valid[NST]) begin
        ser_minus_q <= st_neg[NST];
        ser_idx_q   <= ser_idx_d;
      end
    end else if (out_ready_i) begin
      if (ser_minus_q) begin
        ser_minus_q <= 1'b0;
      end else begin
        ser_idx_q <= ser_idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_ready && st_valid[NST]) begin
      ser_bcd_q <= st_bcd[NST];
    end
  end

  `SITDA_ASSERT_NEXT(a_sign_then_digit,
    out_valid_o && out_ready_i && ser_minus_q,
    out_valid_o && !ser_minus_q,
    "sign not followed by a digit")
  `SITDA_ASSERT_NEXT(a_run_continues,
    out_valid_o && out_ready_i && !last_o,
    out_valid_o && $stable(ser_bcd_q),
    "character run broken before last")
  `SITDA_ASSERT_NOW(a_digit_range,
    out_valid_o && !ser_minus_q,
    character_o >= CHAR_ZERO && character_o <= CHAR_NINE,
    "digit out of range")

endmodule

// ===== sim/testbench.sv =====
// Testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module testbench;
  import sitda_pkg::*;

  localparam int unsigned VW = VALUE_BITS_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [VW-1:0] value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CHAR_W-1:0]    character_o;
  logic                 last_o;

  text_char_t expected_text[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  signed_int_to_decimal_ascii_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Decimal text of one value: magnitude taken one bit wider than the value.
  function automatic void predict_text(input logic signed [VW-1:0] v);
    logic [VW:0]       mag;
    logic [CHAR_W-1:0] digits[$];
    text_char_t        c;
    mag = v[VW-1] ? ({(VW+1){1'b0}} - {v[VW-1], v}) : {1'b0, v};
    do begin
      digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[VW-1]) begin
      c.ch = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch = digits[i];
      c.last = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected char 0x%02h last=%0b", character_o, last_o);
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.ch || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                     want.ch, want.last, character_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_value(input logic signed [VW-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    predict_text(v);
  endtask

  // Hold off requests until every expected character is out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [VW-1:0] random_value();
    logic signed [VW-1:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: r = $urandom_range(99);
      1: r = -$signed(VW'($urandom_range(99)));
      2: r = r >>> $urandom_range(VW - 1);
      default: ;
    endcase
    return r;
  endfunction

  task automatic test_extremes();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value({1'b0, {(VW-1){1'b1}}});
    send_value({1'b1, {(VW-1){1'b0}}});
    send_value({1'b1, {(VW-2){1'b0}}, 1'b1});
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
  endtask

  task automatic test_digit_boundaries();
    send_value(9);
    send_value(10);
    send_value(-10);
    send_value(99);
    send_value(100);
    send_value(-100);
    send_value(999_999_999);
    send_value(1_000_000_000);
    send_value(-999_999_999);
    send_value(-1_000_000_000);
    send_value(-9);
  endtask

  task automatic test_random_mix(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_value(random_value());
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  task automatic test_pause_until_drained();
    send_value(-2147483647);
    send_value(12345);
    wait_drained();
    send_value(-7);
    send_value(2147483646);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    recv_idle_pct = 51;
    test_extremes();
    test_digit_boundaries();
    test_random_mix(30);
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 10;
    test_pause_until_drained();
    test_random_mix(35);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_extremes();
    test_random_mix(35);
    wait_drained();

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
